// ===== rtl/moe_pkg.sv =====
// Shared types and codes for the minicomputer opcode extractor.
// Used by moe_classify and by the top level core; depends on nothing.
package moe_pkg;

   // Widths of the instruction word and the CPU class register.
   localparam int WordWidth  = 16;
   localparam int ClassWidth = 2;

   // CPU class codes.
   localparam logic [ClassWidth-1:0] CLASS_BASE     = 2'd0;
   localparam logic [ClassWidth-1:0] CLASS_EXTENDED = 2'd1;

   // Top-level group codes, taken from bits 15:11 of the word.
   localparam logic [2:0] GRP_MEMREF = 3'd0;
   localparam logic [2:0] GRP_130    = 3'd1;
   localparam logic [2:0] GRP_140    = 3'd2;
   localparam logic [2:0] GRP_144    = 3'd3;
   localparam logic [2:0] GRP_150    = 3'd4;
   localparam logic [2:0] GRP_154    = 3'd5;
   localparam logic [2:0] GRP_170    = 3'd6;
   localparam logic [2:0] GRP_174    = 3'd7;

   // Match results for one word, handed from the classify stage to the select stage.
   typedef struct packed {
      logic [2:0] grp;         // top-level group
      logic       zero_mode;   // 0140000 group with bits 7:6 clear
      logic       exact_140;   // exact word in the 0140000 group (VERSN included)
      logic       user2;       // USER2 group under mask 0xFFC0
      logic       user2_ext;   // listed extended USER2 word on a non-base class
      logic       user3;       // USER3 group under mask 0xFFC0
      logic       user3_ext;   // USER3 on a non-base class keeps bits 2:0
      logic       plain_ffc0;  // plain group returned under mask 0xFFC0
      logic       range_ffc7;  // 0143300..0143306 under mask 0xFFC7
      logic       exact_150;   // exact word in the 0150000 group
      logic       grp_ff00;    // 0150000 subgroup under mask 0xFF00
      logic       grp_ff80;    // 0150000 subgroup under mask 0xFF80
      logic       grp_ffc0;    // 0150000 subgroup under mask 0xFFC0
   } moe_flags_type;

endpackage

// ===== rtl/moe_classify.sv =====
// Match logic of the opcode extractor: compares one instruction word against
// every match group at once and reports the hits. Depends on moe_pkg.
module moe_classify (
   input  logic [moe_pkg::WordWidth-1:0]  word,
   input  logic [moe_pkg::ClassWidth-1:0] cpu_class,
   output moe_pkg::moe_flags_type         flags
);
   import moe_pkg::*;

   // Exact words of the 0140000 group, VERSN excluded.
   function automatic logic is_exact_140(input logic [WordWidth-1:0] w);
      logic hit;
      case (w)
         16'o140120, 16'o140121, 16'o140122, 16'o140123,
         16'o140124, 16'o140125, 16'o140126, 16'o140127,
         16'o140130, 16'o140131, 16'o140132, 16'o140134,
         16'o140135, 16'o140136, 16'o140137,
         16'o140300, 16'o140301, 16'o140302, 16'o140303, 16'o140304,
         16'o143500, 16'o143604, 16'o143611, 16'o143622, 16'o143643: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Extended USER2 words.
   function automatic logic is_user2_ext(input logic [WordWidth-1:0] w);
      logic hit;
      case (w)
         16'o140500, 16'o140501, 16'o140502, 16'o140503,
         16'o140504, 16'o140505, 16'o140506, 16'o140507,
         16'o140510, 16'o140513, 16'o140514, 16'o140515,
         16'o140516, 16'o140517: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Plain groups of the 0140000 range returned under mask 0xFFC0.
   function automatic logic is_plain_ffc0(input logic [WordWidth-1:0] m);
      logic hit;
      case (m)
         16'o140200, 16'o140600, 16'o141100, 16'o141200,
         16'o141300, 16'o141500, 16'o141600, 16'o141700,
         16'o142100, 16'o142200, 16'o142300, 16'o142500,
         16'o142600, 16'o142700, 16'o143100, 16'o143200: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Exact words of the 0150000 group.
   function automatic logic is_exact_150(input logic [WordWidth-1:0] w);
      logic hit;
      case (w)
         16'o150400, 16'o150401, 16'o150402, 16'o150404,
         16'o150405, 16'o150406, 16'o150407, 16'o150410,
         16'o150412, 16'o150415, 16'o150416, 16'o150417: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   logic                 base;
   logic                 versn;
   logic [WordWidth-1:0] m6;
   logic [WordWidth-1:0] m7;
   logic [WordWidth-1:0] m8;
   logic [WordWidth-1:0] m9;

   assign base  = (cpu_class == CLASS_BASE);
   assign versn = (word == 16'o140133) && (cpu_class == CLASS_EXTENDED);
   assign m6    = word & 16'hFFC0;
   assign m7    = word & 16'hFFC7;
   assign m8    = word & 16'hFF00;
   assign m9    = word & 16'hFF80;

   // Top-level group from the five high bits, then the subgroup matches;
   // the select stage applies the priority.
   always_comb begin
      case (word[15:11])
         5'b10110: flags.grp = GRP_130;
         5'b11000: flags.grp = GRP_140;
         5'b11001: flags.grp = GRP_144;
         5'b11010: flags.grp = GRP_150;
         5'b11011: flags.grp = GRP_154;
         5'b11110: flags.grp = GRP_170;
         5'b11111: flags.grp = GRP_174;
         default:  flags.grp = GRP_MEMREF;
      endcase
      flags.zero_mode  = (word[7:6] == 2'b00);
      flags.exact_140  = is_exact_140(word) || versn;
      flags.user2      = (m6 == 16'o140500);
      flags.user2_ext  = !base && is_user2_ext(word);
      flags.user3      = (m6 == 16'o140700);
      flags.user3_ext  = !base;
      flags.plain_ffc0 = is_plain_ffc0(m6);
      flags.range_ffc7 = (m6 == 16'o143300) && (m7[2:0] != 3'b111);
      flags.exact_150  = is_exact_150(word);
      flags.grp_ff00   = (m8 == 16'o151000) || (m8 == 16'o151400) ||
                         (m8 == 16'o152000) || (m8 == 16'o153000);
      flags.grp_ff80   = (m9 == 16'o152400) || (m9 == 16'o152600) ||
                         (m9 == 16'o153400) || (m9 == 16'o153600);
      flags.grp_ffc0   = (m6 == 16'o150000) || (m6 == 16'o150100) ||
                         (m6 == 16'o150200) || (m6 == 16'o150300);
   end

endmodule

// ===== rtl/minicomputer_opcode_extractor_core.sv =====
// Top level of the minicomputer opcode extractor: input register, match stage
// and select stage with output register. Depends on moe_pkg and moe_classify.
//
// The core turns each 16-bit instruction word into its canonical opcode by
// clearing the operand bits. It accepts one word per cycle while the result side
// does not stall, and presents the opcodes in order: the word is registered,
// matched against all groups in the next stage, and the selected opcode is
// registered at the output. Back-pressure on the result side stalls the three
// stages in place. The user must write the CPU class register over the csr port
// only while no items are in flight; the core itself does not enforce this.
// The register reads 0 after reset.
module minicomputer_opcode_extractor_core (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [moe_pkg::ClassWidth-1:0] csr_data,   // cpu_class
   // Instruction input.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [moe_pkg::WordWidth-1:0]  req_tdata,  // [15:0] instruction
   // Opcode output.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [moe_pkg::WordWidth-1:0]  rsp_tdata   // [15:0] opcode
);
   import moe_pkg::*;

   logic [ClassWidth-1:0] cpu_class_ff;
   logic                  v1_ff, v2_ff, v3_ff;
   logic [WordWidth-1:0]  word1_ff, word2_ff;
   logic [WordWidth-1:0]  opcode_ff, opcode_in;
   moe_flags_type         flags_in, flags2_ff;
   logic                  free2, free3;
   logic [WordWidth-1:0]  m6, m7;

   // Configuration register, always ready.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_class_ff <= CLASS_BASE;
      end else if (csr_valid) begin
         cpu_class_ff <= csr_data;
      end
   end

   // A stage can take an item when it is empty or its item moves on.
   assign free3      = !v3_ff || rsp_tready;
   assign free2      = !v2_ff || free3;
   assign req_tready = !v1_ff || free2;

   // Stage 1: input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_tready) begin
         v1_ff <= req_tvalid;
      end
      if (req_tready) begin
         word1_ff <= req_tdata;
      end
   end

   // Stage 2: match flags.
   moe_classify u_classify (
      .word      (word1_ff),
      .cpu_class (cpu_class_ff),
      .flags     (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (free2) begin
         v2_ff <= v1_ff;
      end
      if (free2) begin
         word2_ff  <= word1_ff;
         flags2_ff <= flags_in;
      end
   end

   // Stage 3: priority select of the mask.
   assign m6 = word2_ff & 16'hFFC0;
   assign m7 = word2_ff & 16'hFFC7;

   always_comb begin
      case (flags2_ff.grp)
         GRP_130, GRP_170: opcode_in = word2_ff & 16'hFF00;
         GRP_140: begin
            if (flags2_ff.zero_mode) begin
               opcode_in = 16'o140000;
            end else if (flags2_ff.exact_140) begin
               opcode_in = word2_ff;
            end else if (flags2_ff.user2) begin
               opcode_in = flags2_ff.user2_ext ? word2_ff : m6;
            end else if (flags2_ff.user3) begin
               opcode_in = flags2_ff.user3_ext ? m7 : m6;
            end else if (flags2_ff.plain_ffc0) begin
               opcode_in = m6;
            end else if (flags2_ff.range_ffc7) begin
               opcode_in = m7;
            end else begin
               opcode_in = word2_ff;
            end
         end
         GRP_150: begin
            if (flags2_ff.exact_150) begin
               opcode_in = word2_ff;
            end else if (flags2_ff.grp_ff00) begin
               opcode_in = word2_ff & 16'hFF00;
            end else if (flags2_ff.grp_ff80) begin
               opcode_in = word2_ff & 16'hFF80;
            end else if (flags2_ff.grp_ffc0) begin
               opcode_in = m6;
            end else begin
               opcode_in = word2_ff;
            end
         end
         GRP_144: opcode_in = m6;
         GRP_154: opcode_in = word2_ff & 16'hF980;
         GRP_174: opcode_in = word2_ff & 16'hFF80;
         default: opcode_in = word2_ff & 16'hF800;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (free3) begin
         v3_ff <= v2_ff;
      end
      if (free3) begin
         opcode_ff <= opcode_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = opcode_ff;

   // An empty input stage always takes a new item.
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready) else $error("input stage empty but not ready");

   // A full pipeline with a stalled output takes no new item.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && !rsp_tready |-> !req_tready)
      else $error("full pipeline accepted an item");

   // The 0xFFC0 subgroups of the 0140000 range exclude one another.
   a_subgroups: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $onehot0({flags2_ff.user2, flags2_ff.user3, flags2_ff.plain_ffc0}))
      else $error("overlapping 0140000 subgroups");

   // Reset brings the class back to the base family.
   a_class_reset: assert property (@(posedge clock)
      reset |=> cpu_class_ff == CLASS_BASE) else $error("class not cleared by reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for minicomputer_opcode_extractor_core.
// Drives instruction items, predicts each opcode per CPU class and compares results in order.
// Depends on moe_pkg and the core RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import moe_pkg::*;

   // CPU class codes that the package does not name.
   localparam logic [ClassWidth-1:0] CLASS_OTHER     = 2'd2;
   localparam logic [ClassWidth-1:0] CLASS_UNDEFINED = 2'd3;

   // Words and group bases used by the opcode predictor.
   localparam logic [15:0] WORD_VERSN  = 16'o140133;
   localparam logic [15:0] GROUP_USER2 = 16'o140500;
   localparam logic [15:0] GROUP_USER3 = 16'o140700;

   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 144;
   localparam int HOT_BASES      = 19;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   // Idling modes of the random phases.
   localparam int MODE_NONE     = 0;
   localparam int MODE_SENDER   = 1;
   localparam int MODE_RECEIVER = 2;
   localparam int MODE_BOTH     = 3;

   // One row of the directed table: class, whether the opcode is typed in, word, opcode.
   typedef struct packed {
      logic [ClassWidth-1:0] cls;
      logic                  typed;
      logic [15:0]           word;
      logic [15:0]           opcode;
   } directed_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [ClassWidth-1:0] csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WordWidth-1:0]  req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [WordWidth-1:0]  rsp_tdata;

   logic [ClassWidth-1:0] cpu_class_now = CLASS_BASE;
   logic [15:0]           opcode_q[$];
   int                    mismatch_count = 0;
   int                    idle_pct  = 0;
   int                    stall_pct = 0;
   int                    quiet_cycles = 0;

   minicomputer_opcode_extractor_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] instruction
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [15:0] opcode
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Decoding of the 0140000 group once bits 7:6 are known to be nonzero.
   function automatic logic [15:0] decode_group_140(input logic [15:0] w,
                                                   input logic [ClassWidth-1:0] cls);
      logic [15:0] m6;
      logic [15:0] m7;
      logic        base;
      m6   = w & 16'hFFC0;
      m7   = w & 16'hFFC7;
      base = (cls == CLASS_BASE);
      case (w)
         16'o140120, 16'o140121, 16'o140122, 16'o140123, 16'o140124, 16'o140125,
         16'o140126, 16'o140127, 16'o140130, 16'o140131, 16'o140132, 16'o140134,
         16'o140135, 16'o140136, 16'o140137, 16'o140300, 16'o140301, 16'o140302,
         16'o140303, 16'o140304, 16'o143500, 16'o143604, 16'o143611, 16'o143622,
         16'o143643: return w;
         default: ;
      endcase
      if (w == WORD_VERSN && cls == CLASS_EXTENDED)
         return w;
      // USER2: listed extended words survive whole on non-base classes.
      if (m6 == GROUP_USER2) begin
         if (!base) begin
            case (w)
               16'o140500, 16'o140501, 16'o140502, 16'o140503, 16'o140504,
               16'o140505, 16'o140506, 16'o140507, 16'o140510, 16'o140513,
               16'o140514, 16'o140515, 16'o140516, 16'o140517: return w;
               default: ;
            endcase
         end
         return m6;
      end
      // USER3 keeps bits 2:0 on non-base classes.
      if (m6 == GROUP_USER3)
         return base ? m6 : m7;
      case (m6)
         16'o140200, 16'o140600, 16'o141100, 16'o141200, 16'o141300, 16'o141500,
         16'o141600, 16'o141700, 16'o142100, 16'o142200, 16'o142300, 16'o142500,
         16'o142600, 16'o142700, 16'o143100, 16'o143200: return m6;
         default: ;
      endcase
      if (m7 >= 16'o143300 && m7 <= 16'o143306)
         return m7;
      return w;
   endfunction

   // Decoding of the 0150000 group: exact words first, then narrowing masks.
   function automatic logic [15:0] decode_group_150(input logic [15:0] w);
      logic [15:0] m;
      case (w)
         16'o150400, 16'o150401, 16'o150402, 16'o150404, 16'o150405, 16'o150406,
         16'o150407, 16'o150410, 16'o150412, 16'o150415, 16'o150416,
         16'o150417: return w;
         default: ;
      endcase
      m = w & 16'hFF00;
      case (m)
         16'o151000, 16'o151400, 16'o152000, 16'o153000: return m;
         default: ;
      endcase
      m = w & 16'hFF80;
      case (m)
         16'o152400, 16'o152600, 16'o153400, 16'o153600: return m;
         default: ;
      endcase
      m = w & 16'hFFC0;
      case (m)
         16'o150000, 16'o150100, 16'o150200, 16'o150300: return m;
         default: ;
      endcase
      return w;
   endfunction

   // Canonical opcode of one instruction word under the given CPU class.
   function automatic logic [15:0] canonical_opcode(input logic [15:0] w,
                                                   input logic [ClassWidth-1:0] cls);
      case (w & 16'hF800)
         16'o130000: return w & 16'hFF00;
         16'o140000: return ((w & 16'h00C0) == 16'h0000) ? 16'o140000
                                                          : decode_group_140(w, cls);
         16'o150000: return decode_group_150(w);
         16'o144000: return w & 16'hFFC0;
         16'o154000: return w & 16'hF980;
         16'o170000: return w & 16'hFF00;
         16'o174000: return w & 16'hFF80;
         default:    return w & 16'hF800;
      endcase
   endfunction

   // Directed table: extremes, every group and the class-dependent corner words.
   function automatic directed_row_type directed_row(input int i);
      case (i)
         0:  return {CLASS_BASE,      1'b1, 16'o000000, 16'o000000};
         1:  return {CLASS_BASE,      1'b1, 16'o177777, 16'o177600};
         2:  return {CLASS_BASE,      1'b1, 16'o140077, 16'o140000};
         3:  return {CLASS_BASE,      1'b1, WORD_VERSN, WORD_VERSN};
         4:  return {CLASS_BASE,      1'b0, 16'o140507, 16'o000000};
         5:  return {CLASS_BASE,      1'b0, 16'o140705, 16'o000000};
         6:  return {CLASS_BASE,      1'b0, 16'o143304, 16'o000000};
         7:  return {CLASS_BASE,      1'b0, 16'o143307, 16'o000000};
         8:  return {CLASS_BASE,      1'b0, 16'o150417, 16'o000000};
         9:  return {CLASS_BASE,      1'b0, 16'o151377, 16'o000000};
         10: return {CLASS_BASE,      1'b0, 16'o152577, 16'o000000};
         11: return {CLASS_BASE,      1'b0, 16'o150377, 16'o000000};
         12: return {CLASS_BASE,      1'b0, 16'o150777, 16'o000000};
         13: return {CLASS_BASE,      1'b0, 16'o130377, 16'o000000};
         14: return {CLASS_BASE,      1'b0, 16'o144377, 16'o000000};
         15: return {CLASS_BASE,      1'b0, 16'o157777, 16'o000000};
         16: return {CLASS_BASE,      1'b0, 16'o170377, 16'o000000};
         17: return {CLASS_BASE,      1'b0, 16'o141177, 16'o000000};
         18: return {CLASS_BASE,      1'b0, 16'o143622, 16'o000000};
         19: return {CLASS_BASE,      1'b0, 16'o047777, 16'o000000};
         20: return {CLASS_EXTENDED,  1'b1, WORD_VERSN, WORD_VERSN};
         21: return {CLASS_EXTENDED,  1'b0, 16'o140507, 16'o000000};
         22: return {CLASS_EXTENDED,  1'b0, 16'o140705, 16'o000000};
         23: return {CLASS_OTHER,     1'b0, 16'o140511, 16'o000000};
         default: return {CLASS_UNDEFINED, 1'b0, 16'o140707, 16'o000000};
      endcase
   endfunction

   // Group bases that random words are built around.
   function automatic logic [15:0] hot_base(input int i);
      case (i)
         0:  return GROUP_USER2;
         1:  return GROUP_USER3;
         2:  return 16'o143300;
         3:  return 16'o140120;
         4:  return 16'o140300;
         5:  return 16'o143600;
         6:  return 16'o150400;
         7:  return 16'o151000;
         8:  return 16'o152400;
         9:  return 16'o153600;
         10: return 16'o150000;
         11: return 16'o140100;
         12: return 16'o141100;
         13: return 16'o142700;
         14: return 16'o130000;
         15: return 16'o144000;
         16: return 16'o154000;
         17: return 16'o170000;
         default: return 16'o174000;
      endcase
   endfunction

   // Mostly words inside the decode groups, with plain noise mixed in.
   function automatic logic [15:0] random_word();
      int          pick;
      logic [15:0] low_mask;
      pick = $urandom_range(99);
      if (pick < 20)
         return 16'($urandom);
      if (pick < 45)
         return 16'o140000 | (16'($urandom) & 16'h07FF);
      if (pick < 60)
         return 16'o150000 | (16'($urandom) & 16'h07FF);
      low_mask = (16'h0001 << $urandom_range(7)) - 16'h0001;
      return hot_base($urandom_range(HOT_BASES - 1)) | (16'($urandom) & low_mask);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s: got %06o, wanted %06o", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Offer one instruction item and hold it until it is taken.
   task automatic send_word(input logic [15:0] word, input logic typed,
                            input logic [15:0] typed_opcode);
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      opcode_q.push_back(typed ? typed_opcode : canonical_opcode(word, cpu_class_now));
   endtask

   // Stop sending and wait for every expected opcode to arrive.
   task automatic drain_opcodes();
      req_tvalid <= 1'b0;
      while (opcode_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_class(input logic [ClassWidth-1:0] cls);
      csr_data  <= cls;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      cpu_class_now  = cls;
   endtask

   // Receiver side: stall at random according to the current phase.
   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
   end

   // Compare each accepted opcode with the oldest expectation.
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (opcode_q.size() == 0) begin
            report_mismatch("opcode with nothing expected", rsp_tdata, 16'h0000);
         end else begin
            want = opcode_q.pop_front();
            if (rsp_tdata !== want)
               report_mismatch("opcode", rsp_tdata, want);
         end
      end
   end

   // Watchdog: end the run if no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: reset, directed table, then random phases across classes and idling modes.
   initial begin
      directed_row_type row;
      int               mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_class(CLASS_BASE);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         if (row.cls != cpu_class_now) begin
            drain_opcodes();
            write_class(row.cls);
         end
         send_word(row.word, row.typed, row.opcode);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_opcodes();
         write_class(ClassWidth'(phase % 4));
         mode = phase / 2;
         idle_pct  = (mode == MODE_SENDER) ? 53 : (mode == MODE_BOTH) ? 29 : 0;
         stall_pct = (mode == MODE_RECEIVER) ? 53 : (mode == MODE_BOTH) ? 29 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Midway through one phase, let the pipeline run empty before going on.
            if (phase == 3 && n == PHASE_ITEMS / 2)
               drain_opcodes();
            while ($urandom_range(99) < idle_pct) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
            end
            send_word(random_word(), 1'b0, 16'h0000);
         end
      end

      drain_opcodes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== minicomputer_opcode_extractor_core.f =====
rtl/moe_pkg.sv
rtl/moe_classify.sv
rtl/minicomputer_opcode_extractor_core.sv
tb/testbench.sv
